// ----- hdl/lrqm_pkg.sv -----
package lrqm_pkg;

  // event codes
  localparam logic [1:0] OP_SENT     = 2'd0;
  localparam logic [1:0] OP_RECEIVED = 2'd1;
  localparam logic [1:0] OP_RESPONSE = 2'd2;
  localparam logic [1:0] OP_EVALUATE = 2'd3;

  // quality levels
  localparam logic [2:0] LVL_UNKNOWN  = 3'd0;
  localparam logic [2:0] LVL_GOOD     = 3'd1;
  localparam logic [2:0] LVL_DEGRADED = 3'd2;
  localparam logic [2:0] LVL_POOR     = 3'd3;
  localparam logic [2:0] LVL_CRITICAL = 3'd4;

  // register indexes
  localparam logic REG_TIMEOUT_LIMIT    = 1'b0;
  localparam logic REG_HEARTBEAT_PERIOD = 1'b1;

  localparam int LIMIT_W  = 20;
  localparam int PERIOD_W = 16;
  localparam int CFG_W    = 20;

  localparam logic [LIMIT_W-1:0]  TIMEOUT_LIMIT_RESET    = 20'd10000;
  localparam logic [PERIOD_W-1:0] HEARTBEAT_PERIOD_RESET = 16'd1000;

  // classification thresholds, ms
  localparam logic [31:0] GOOD_AVG_MAX     = 32'd80;
  localparam logic [31:0] GOOD_JITTER_MAX  = 32'd25;
  localparam logic [31:0] DEGR_AVG_MAX     = 32'd180;
  localparam logic [31:0] DEGR_JITTER_MAX  = 32'd80;
  localparam logic [31:0] POOR_AVG_MAX     = 32'd450;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] time_now_ms;
    logic [31:0] probe_id;
    logic        link_active;
  } event_t;

  typedef struct packed {
    logic [31:0] rtt_value;
    logic [31:0] rtt_average;
    logic [31:0] rtt_variation;
  } stats_t;

endpackage

// ----- hdl/link_rtt_quality_monitor.sv -----
// Link RTT quality monitor: tracks one link from heartbeat words. A sent word
// records send time and probe id; received and response words record the last
// receive time. A response whose id matches a nonzero stored id, with a nonzero
// send time not later than now, updates the RTT, the 7/8 smoothed RTT and the
// 3/4 jitter (each seeded directly while zero). An evaluate word grades the
// link (unknown, good, degraded, poor, critical) and flags a timeout. Every
// input word yields exactly one result word. Throughput is one word per clock
// while out_stall is low; a word passes through the input register and then
// the result register, with all state updated in the single combinational
// pass between them. Configuration writes take effect at the next edge.
module link_rtt_quality_monitor (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [lrqm_pkg::CFG_W-1:0]   cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic [31:0]                  time_now_ms,
  input  logic [31:0]                  probe_id,
  input  logic                         link_active,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         response_accepted,
  output logic [2:0]                   quality_level,
  output logic                         timed_out,
  output logic [31:0]                  last_rtt_ms,
  output logic [31:0]                  smoothed_rtt_ms,
  output logic [31:0]                  jitter_ms
);
  import lrqm_pkg::*;

  // configuration registers
  logic [LIMIT_W-1:0]  timeout_limit_ms;
  logic [PERIOD_W-1:0] heartbeat_period_ms;

  // input register
  event_t in_word;
  logic   in_word_valid;

  // link state
  logic [31:0] sent_time;
  logic [31:0] sent_probe;
  logic [31:0] recv_time;
  stats_t      stats;
  logic [2:0]  link_quality;

  logic   in_take;
  logic   advance;
  logic   matched;
  stats_t stats_resp;
  logic [2:0] quality_eval;
  logic   timeout_eval;

  // the word in the input register moves on when the result slot is free
  assign advance  = in_word_valid && (!out_valid || !out_stall);
  assign in_stall = in_word_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit_ms    <= TIMEOUT_LIMIT_RESET;
      heartbeat_period_ms <= HEARTBEAT_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TIMEOUT_LIMIT:    timeout_limit_ms    <= cfg_data[LIMIT_W-1:0];
        REG_HEARTBEAT_PERIOD: heartbeat_period_ms <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word_valid <= 1'b0;
    end else if (in_take) begin
      in_word_valid <= 1'b1;
    end else if (advance) begin
      in_word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word.operation   <= operation;
      in_word.time_now_ms <= time_now_ms;
      in_word.probe_id    <= probe_id;
      in_word.link_active <= link_active;
    end
  end

  lrqm_rtt_update u_rtt_update (
    .time_now_ms (in_word.time_now_ms),
    .probe_id    (in_word.probe_id),
    .sent_time   (sent_time),
    .sent_probe  (sent_probe),
    .stats       (stats),
    .matched     (matched),
    .stats_next  (stats_resp)
  );

  lrqm_classify u_classify (
    .time_now_ms         (in_word.time_now_ms),
    .link_active         (in_word.link_active),
    .recv_time           (recv_time),
    .rtt_average         (stats.rtt_average),
    .rtt_variation       (stats.rtt_variation),
    .timeout_limit_ms    (timeout_limit_ms),
    .heartbeat_period_ms (heartbeat_period_ms),
    .quality             (quality_eval),
    .timed_out           (timeout_eval)
  );

  // state and result flags change only when a word moves to the result slot,
  // so the stored statistics double as the result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_time    <= 32'd0;
      sent_probe   <= 32'd0;
      recv_time    <= 32'd0;
      stats        <= '0;
      link_quality <= LVL_UNKNOWN;
    end else if (advance) begin
      unique case (in_word.operation)
        OP_SENT: begin
          sent_time  <= in_word.time_now_ms;
          sent_probe <= in_word.probe_id;
        end
        OP_RECEIVED: begin
          recv_time <= in_word.time_now_ms;
        end
        OP_RESPONSE: begin
          recv_time <= in_word.time_now_ms;
          stats     <= stats_resp;
        end
        OP_EVALUATE: begin
          link_quality <= quality_eval;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      response_accepted <= (in_word.operation == OP_RESPONSE) && matched;
      timed_out         <= (in_word.operation == OP_EVALUATE) && timeout_eval;
    end
  end

  assign quality_level   = link_quality;
  assign last_rtt_ms     = stats.rtt_value;
  assign smoothed_rtt_ms = stats.rtt_average;
  assign jitter_ms       = stats.rtt_variation;

endmodule

// ----- hdl/lrqm_rtt_update.sv -----
module lrqm_rtt_update (
  input  logic [31:0]     time_now_ms,
  input  logic [31:0]     probe_id,
  input  logic [31:0]     sent_time,
  input  logic [31:0]     sent_probe,
  input  lrqm_pkg::stats_t stats,
  output logic            matched,
  output lrqm_pkg::stats_t stats_next
);
  import lrqm_pkg::*;

  logic [31:0] rtt;
  logic [31:0] sample;
  logic [34:0] avg_sum;
  logic [33:0] jit_sum;
  logic [31:0] avg_new;
  logic [31:0] jit_new;

  assign matched = (sent_probe != 32'd0) && (probe_id == sent_probe) &&
                   (sent_time != 32'd0) && (time_now_ms >= sent_time);

  assign rtt    = time_now_ms - sent_time;
  assign sample = (rtt > stats.rtt_value) ? (rtt - stats.rtt_value)
                                          : (stats.rtt_value - rtt);

  // 7*avg + rtt and 3*jitter + sample, kept wide
  assign avg_sum = {stats.rtt_average, 3'b000} - {3'b000, stats.rtt_average}
                   + {3'b000, rtt};
  assign jit_sum = {1'b0, stats.rtt_variation, 1'b0} + {2'b00, stats.rtt_variation}
                   + {2'b00, sample};

  assign avg_new = (stats.rtt_average == 32'd0) ? rtt : avg_sum[34:3];
  assign jit_new = (stats.rtt_variation == 32'd0) ? sample : jit_sum[33:2];

  always_comb begin
    stats_next = stats;
    if (matched) begin
      stats_next.rtt_value     = rtt;
      stats_next.rtt_average   = avg_new;
      stats_next.rtt_variation = jit_new;
    end
  end

endmodule

// ----- hdl/lrqm_classify.sv -----
module lrqm_classify (
  input  logic [31:0]                   time_now_ms,
  input  logic                          link_active,
  input  logic [31:0]                   recv_time,
  input  logic [31:0]                   rtt_average,
  input  logic [31:0]                   rtt_variation,
  input  logic [lrqm_pkg::LIMIT_W-1:0]  timeout_limit_ms,
  input  logic [lrqm_pkg::PERIOD_W-1:0] heartbeat_period_ms,
  output logic [2:0]                    quality,
  output logic                          timed_out
);
  import lrqm_pkg::*;

  logic        have_recv;
  logic [31:0] raw_gap;
  logic [31:0] gap;
  logic [31:0] limit;
  logic [PERIOD_W+1:0] per2;
  logic [PERIOD_W+1:0] per3;

  assign have_recv = (recv_time != 32'd0);
  assign raw_gap   = time_now_ms - recv_time;
  // no wrap for the quality gap
  assign gap       = (have_recv && (time_now_ms >= recv_time)) ? raw_gap : 32'd0;
  assign limit     = {{(32-LIMIT_W){1'b0}}, timeout_limit_ms};
  assign per2      = {1'b0, heartbeat_period_ms, 1'b0};
  assign per3      = per2 + {2'b00, heartbeat_period_ms};

  always_comb begin
    if (gap > limit) begin
      quality = LVL_CRITICAL;
    end else if (rtt_average == 32'd0) begin
      quality = LVL_UNKNOWN;
    end else if ((rtt_average < GOOD_AVG_MAX) && (rtt_variation < GOOD_JITTER_MAX) &&
                 (gap <= {{(32-PERIOD_W-2){1'b0}}, per2})) begin
      quality = LVL_GOOD;
    end else if ((rtt_average < DEGR_AVG_MAX) && (rtt_variation < DEGR_JITTER_MAX) &&
                 (gap <= {{(32-PERIOD_W-2){1'b0}}, per3})) begin
      quality = LVL_DEGRADED;
    end else if (rtt_average < POOR_AVG_MAX) begin
      quality = LVL_POOR;
    end else begin
      quality = LVL_CRITICAL;
    end
  end

  // timeout gap wraps
  assign timed_out = link_active && have_recv && (raw_gap > limit);

endmodule
